@@ rtl/core/ascii_sensor_frame_parser_defines.svh @@
// ----------------------------------------------------------------------------
// ASCII sensor frame parser assertion macros
// Shared property wrappers for the checker of the frame parser.
// ----------------------------------------------------------------------------
`ifndef ASCII_SENSOR_FRAME_PARSER_DEFINES_SVH
`define ASCII_SENSOR_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASFP_ASSERT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ASFP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/asfp_pkg.sv @@
// ----------------------------------------------------------------------------
// ASCII sensor frame parser package
// Character codes, parser state encodings and the parser state record.
// ----------------------------------------------------------------------------
`default_nettype none

package asfp_pkg;

  // Default frame length limit in bytes
  localparam int unsigned FRAME_BYTES_DEF = 32;

  // Character codes
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_HT    = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_POINT = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_EQUAL = 8'h3D;
  localparam logic [7:0] CHAR_R     = 8'h72;
  localparam logic [7:0] CHAR_S     = 8'h73;
  localparam logic [7:0] CHAR_T     = 8'h74;
  localparam logic [7:0] CHAR_V     = 8'h76;

  // Saturation limits of the value accumulator
  localparam logic [31:0] SAT_MAG = 32'h8000_0000;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

  // Frame terminator tracking
  typedef enum logic [1:0] {
    TERM_IDLE,
    TERM_CR,
    TERM_CRLF
  } term_e;

  // Progress of the open token against the keys
  typedef enum logic [2:0] {
    KEY_EMPTY,
    KEY_V,
    KEY_VV,
    KEY_S,
    KEY_ST,
    KEY_STR,
    KEY_NONE
  } key_e;

  // Kind of value expected in the next token
  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_VEL,
    PEND_INT
  } pend_e;

  // Number reader phase
  typedef enum logic [2:0] {
    NUM_WS,
    NUM_SIGN,
    NUM_INT,
    NUM_POINT,
    NUM_FRAC,
    NUM_END
  } num_e;

  // Token and value parser state
  typedef struct packed {
    logic        halted;
    logic        in_token;
    key_e        key;
    pend_e       pend;
    num_e        nphase;
    logic        neg;
    logic [31:0] accum;
    logic [31:0] vel;
    logic [31:0] inten;
  } parse_t;

endpackage

`default_nettype wire

@@ rtl/core/ascii_sensor_frame_parser.sv @@
// A result is registered into the output or, if that is full, the skid register.
// Throughput: one byte per cycle unless stalled; a single registered parser pass.
// A two-entry output buffer lets bytes flow while a result waits; input stalls
// only when both entries hold results.
// Reset clears the parser state, terminator tracking, byte count and valid flags.
// ----------------------------------------------------------------------------
// ASCII sensor frame parser
// Splits a byte stream into CR LF CR terminated frames and extracts the
// velocity (tenths) and intensity values of each frame.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_sensor_frame_parser
  import asfp_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      velocity_tenths_o,
  output logic [31:0]      intensity_o
);

  localparam int unsigned CntW = $clog2(FRAME_BYTES);
  localparam logic [CntW-1:0] CntLast = CntW'(FRAME_BYTES - 1);

  // Signed result of the accumulated magnitude
  function automatic logic [31:0] signed_val(input logic neg, input logic [31:0] mag);
    logic [31:0] r;
    if (neg) begin
      r = 32'd0 - mag;
    end else begin
      r = (mag > POS_MAX) ? POS_MAX : mag;
    end
    return r;
  endfunction

  // Close the open token: commit a value or arm a key
  function automatic parse_t end_tok(input parse_t s);
    parse_t r;
    r = s;
    if (s.in_token) begin
      r.in_token = 1'b0;
      if (s.pend == PEND_VEL) begin
        r.vel  = signed_val(s.neg, s.accum);
        r.pend = PEND_NONE;
      end else if (s.pend == PEND_INT) begin
        r.inten = signed_val(s.neg, s.accum);
        r.pend  = PEND_NONE;
      end else if (s.key == KEY_V || s.key == KEY_VV) begin
        r.pend = PEND_VEL;
      end else if (s.key == KEY_STR) begin
        r.pend = PEND_INT;
      end
    end
    return r;
  endfunction

  // One byte of a value token
  function automatic parse_t feed_num(input parse_t s, input logic [7:0] c);
    parse_t      r;
    logic        is_vel;
    logic        is_dig;
    logic [3:0]  d;
    logic [6:0]  dv;
    logic [35:0] prod;
    logic [32:0] fsum;
    num_e        ph;
    logic        go;
    r      = s;
    is_vel = (s.pend == PEND_VEL);
    is_dig = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    d      = is_dig ? 4'(c - CHAR_ZERO) : 4'd0;
    dv     = is_vel ? ((7'(d) << 3) + (7'(d) << 1)) : 7'(d);
    prod   = ({4'd0, s.accum} << 3) + ({4'd0, s.accum} << 1) + 36'(dv);
    fsum   = {1'b0, s.accum} + 33'(d);
    ph     = s.nphase;
    go     = 1'b1;
    // Leading whitespace and sign
    if (ph == NUM_WS) begin
      if (c >= CHAR_HT && c <= CHAR_CR) begin
        go = 1'b0;
      end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
        r.neg    = (c == CHAR_MINUS);
        r.nphase = NUM_SIGN;
        go       = 1'b0;
      end else begin
        ph = NUM_SIGN;
      end
    end
    if (go) begin
      case (ph) inside
        NUM_SIGN, NUM_INT: begin
          if (is_dig) begin
            r.accum  = (prod > 36'(SAT_MAG)) ? SAT_MAG : prod[31:0];
            r.nphase = NUM_INT;
          end else if (c == CHAR_POINT && is_vel) begin
            r.nphase = NUM_POINT;
          end else begin
            r.nphase = NUM_END;
          end
        end
        NUM_POINT: begin
          if (is_dig) begin
            r.accum  = (fsum > 33'(SAT_MAG)) ? SAT_MAG : fsum[31:0];
            r.nphase = NUM_FRAC;
          end else begin
            r.nphase = NUM_END;
          end
        end
        NUM_FRAC: begin
          if (!is_dig) begin
            r.nphase = NUM_END;
          end
        end
        default: begin
        end
      endcase
    end
    return r;
  endfunction

  parse_t         st_q, st_d;
  term_e          term_q, term_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic           complete;
  logic [31:0]    res_vel, res_int;

  logic           in_acc;
  logic           push, pop;
  logic           out_vld_q, skid_vld_q;
  logic [31:0]    out_vel_q, out_int_q, skid_vel_q, skid_int_q;

  assign in_acc = in_valid_i && !in_stall_o;

  // Per-byte parser update
  always_comb begin
    parse_t s;
    s = st_q;
    if (!s.halted) begin
      if (rx_byte_i == CHAR_NUL) begin
        s        = end_tok(s);
        s.halted = 1'b1;
      end else if (rx_byte_i == CHAR_SPACE || rx_byte_i == CHAR_COMMA ||
                   rx_byte_i == CHAR_EQUAL) begin
        s = end_tok(s);
      end else begin
        if (!s.in_token) begin
          s.in_token = 1'b1;
          s.key      = KEY_EMPTY;
          s.nphase   = NUM_WS;
          s.neg      = 1'b0;
          s.accum    = '0;
        end
        if (s.pend != PEND_NONE) begin
          s = feed_num(s, rx_byte_i);
        end else begin
          if (s.key == KEY_EMPTY && rx_byte_i == CHAR_V) begin
            s.key = KEY_V;
          end else if (s.key == KEY_EMPTY && rx_byte_i == CHAR_S) begin
            s.key = KEY_S;
          end else if (s.key == KEY_V && rx_byte_i == CHAR_V) begin
            s.key = KEY_VV;
          end else if (s.key == KEY_S && rx_byte_i == CHAR_T) begin
            s.key = KEY_ST;
          end else if (s.key == KEY_ST && rx_byte_i == CHAR_R) begin
            s.key = KEY_STR;
          end else begin
            s.key = KEY_NONE;
          end
        end
      end
    end

    // Terminator tracking, no overlap on a broken match
    complete = 1'b0;
    term_d   = TERM_IDLE;
    unique case (term_q)
      TERM_IDLE: term_d = (rx_byte_i == CHAR_CR) ? TERM_CR : TERM_IDLE;
      TERM_CR:   term_d = (rx_byte_i == CHAR_LF) ? TERM_CRLF : TERM_IDLE;
      TERM_CRLF: begin
        complete = (rx_byte_i == CHAR_CR);
        term_d   = complete ? TERM_CRLF : TERM_IDLE;
      end
      default:   term_d = TERM_IDLE;
    endcase

    // Frame end, overflow drop, or continue
    if (complete && !s.halted) begin
      s = end_tok(s);
    end
    res_vel = s.vel;
    res_int = s.inten;
    if (complete || cnt_q == CntLast) begin
      st_d   = '0;
      term_d = TERM_IDLE;
      cnt_d  = '0;
    end else begin
      st_d   = s;
      cnt_d  = cnt_q + CntW'(1);
    end
  end

  // Parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= '0;
      term_q <= TERM_IDLE;
      cnt_q  <= '0;
    end else if (in_acc) begin
      st_q   <= st_d;
      term_q <= term_d;
      cnt_q  <= cnt_d;
    end
  end

  // Two-entry result buffer: output register plus skid register
  assign push = in_acc && complete;
  assign pop  = out_vld_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (pop) begin
        skid_vld_q <= 1'b0;
      end
    end else if (push) begin
      if (!out_vld_q || pop) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (pop) begin
      out_vld_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) begin
        out_vel_q <= skid_vel_q;
        out_int_q <= skid_int_q;
      end
    end else if (push) begin
      if (!out_vld_q || pop) begin
        out_vel_q <= res_vel;
        out_int_q <= res_int;
      end else begin
        skid_vel_q <= res_vel;
        skid_int_q <= res_int;
      end
    end
  end

  assign in_stall_o        = skid_vld_q;
  assign out_valid_o       = out_vld_q;
  assign velocity_tenths_o = out_vel_q;
  assign intensity_o       = out_int_q;

endmodule

`default_nettype wire

@@ rtl/core/asfp_checker.sv @@
// ----------------------------------------------------------------------------
// ASCII sensor frame parser checker
// Port-level properties of the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ascii_sensor_frame_parser_defines.svh"

module asfp_checker
  import asfp_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [7:0]  rx_byte_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] velocity_tenths_o,
  input wire logic [31:0] intensity_o
);

  // A new result follows an accepted transaction
  `ASFP_ASSERT(a_res_after_acc, clk_i, rst_ni, $rose(out_valid_o), $past(in_valid_i && !in_stall_o), "result without accepted byte")

  // A new result follows a CR byte
  `ASFP_ASSERT(a_res_after_cr, clk_i, rst_ni, $rose(out_valid_o), $past(rx_byte_i) == CHAR_CR, "result not closed by CR")

  // Input stalls only while a result is waiting
  `ASFP_ASSERT(a_stall_full, clk_i, rst_ni, in_stall_o, out_valid_o, "input stalled with empty output")

  // A stalled result holds
  `ASFP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(velocity_tenths_o) && $stable(intensity_o), "stalled result changed")

endmodule

bind ascii_sensor_frame_parser asfp_checker u_asfp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .rx_byte_i         (rx_byte_i),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .velocity_tenths_o (velocity_tenths_o),
  .intensity_o       (intensity_o)
);

`default_nettype wire
